// ----- design/uida_pkg.sv -----
// Shared constants, codes and controller/datapath types of the unique ID allocator.
package uida_pkg;

    // Sizing
    localparam int TABLE_DEPTH = 32;
    localparam int PID_LIMIT   = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PID_W       = $clog2(PID_LIMIT);
    localparam int ID_W        = $clog2(PID_LIMIT + 1);

    // Fixed field widths of the channels
    localparam int OPCODE_W = 1;
    localparam int REL_W    = 6;
    localparam int GIVEN_W  = 6;
    localparam int STATUS_W = 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic alloc_step;
        logic rel_step;
        logic finish;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic in_release;
        logic in_full;
        logic in_scan;
        logic scan_last;
        logic rel_last;
        logic out_free;
    } t_stat;

endpackage

// ----- design/uida_in_if.sv -----
// Request channel: opcode and ID to release.
interface uida_in_if;
    logic                           valid;
    logic                           ready;
    logic [uida_pkg::OPCODE_W-1:0]  opcode;
    logic [uida_pkg::REL_W-1:0]     release_id;

    modport source (output valid, output opcode, output release_id, input ready);
    modport sink   (input valid, input opcode, input release_id, output ready);
endinterface

// ----- design/uida_out_if.sv -----
// Result channel: allocated ID and status.
interface uida_out_if;
    logic                           valid;
    logic                           ready;
    logic [uida_pkg::GIVEN_W-1:0]   given_id;
    logic [uida_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output given_id, output status, input ready);
    modport sink   (input valid, input given_id, input status, output ready);
endinterface

// ----- design/uida_ctrl.sv -----
// Controller state machine: accept, scan the table, deliver the result.
module uida_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  uida_pkg::t_stat    i_stat,
    output logic               o_in_ready,
    output uida_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ASCAN = 2'd1;
    localparam logic [1:0] S_RSCAN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Decode next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_release) begin
                        n_state = S_RSCAN;
                    end else if (!i_stat.in_full && i_stat.in_scan) begin
                        n_state = S_ASCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_ASCAN: begin
                o_cmd.alloc_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_RSCAN: begin
                o_cmd.rel_step = 1'b1;
                if (i_stat.rel_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/uida_datapath.sv -----
// Datapath: ID table, valid bits, counters, scan registers and result register.
module uida_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  uida_pkg::t_cmd                  i_cmd,
    output uida_pkg::t_stat                 o_stat,
    input  logic [uida_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [uida_pkg::REL_W-1:0]      i_release_id,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [uida_pkg::GIVEN_W-1:0]    o_given_id,
    output logic [uida_pkg::STATUS_W-1:0]   o_status
);

    localparam logic [uida_pkg::ID_W-1:0]  LIMIT_ID = uida_pkg::ID_W'(uida_pkg::PID_LIMIT);
    localparam logic [uida_pkg::ID_W-1:0]  ONE_ID   = uida_pkg::ID_W'(1);
    localparam logic [uida_pkg::IDX_W-1:0] LAST_IDX =
        uida_pkg::IDX_W'(uida_pkg::TABLE_DEPTH - 1);

    logic [uida_pkg::PID_W-1:0]      r_table [uida_pkg::TABLE_DEPTH];
    logic [uida_pkg::TABLE_DEPTH-1:0] r_valid;
    logic [uida_pkg::CNT_W-1:0]      r_count;
    logic [uida_pkg::ID_W-1:0]       r_last;
    logic [uida_pkg::ID_W-1:0]       r_safe;
    logic [uida_pkg::ID_W-1:0]       r_cand;
    logic [uida_pkg::ID_W-1:0]       r_bound;
    logic [uida_pkg::IDX_W-1:0]      r_idx;
    logic [uida_pkg::PID_W-1:0]      r_ent;
    logic [uida_pkg::OPCODE_W-1:0]   r_op;
    logic [uida_pkg::REL_W-1:0]      r_rel;
    logic                            r_full;
    logic                            r_hit;
    logic [uida_pkg::IDX_W-1:0]      r_hit_idx;
    logic                            r_out_valid;
    logic [uida_pkg::GIVEN_W-1:0]    r_out_given;
    logic [uida_pkg::STATUS_W-1:0]   r_out_status;

    logic [uida_pkg::ID_W-1:0]  start_inc;
    logic                       start_wrap;
    logic [uida_pkg::ID_W-1:0]  start_cand;
    logic                       ent_vld;
    logic [uida_pkg::ID_W-1:0]  ent_id;
    logic                       cand_hit;
    logic [uida_pkg::ID_W-1:0]  cand_inc;
    logic                       restart;
    logic [uida_pkg::ID_W-1:0]  n_cand;
    logic [uida_pkg::ID_W-1:0]  n_bound;
    logic [uida_pkg::IDX_W-1:0] n_idx;
    logic                       idx_last;
    logic                       rel_hit;
    logic [uida_pkg::IDX_W-1:0] free_idx;

    // Starting candidate and full check for a new request
    assign start_inc  = r_last + ONE_ID;
    assign start_wrap = (start_inc >= LIMIT_ID);
    assign start_cand = start_wrap ? ONE_ID : start_inc;

    assign o_stat.in_release = (i_opcode == uida_pkg::OP_RELEASE);
    assign o_stat.in_full    = (int'(r_count) >= uida_pkg::TABLE_DEPTH) ||
                               (int'(r_count) >= uida_pkg::PID_LIMIT - 1);
    assign o_stat.in_scan    = start_wrap || (start_inc >= r_safe);

    // Examine the current table entry
    assign ent_vld  = r_valid[r_idx];
    assign ent_id   = uida_pkg::ID_W'(r_ent);
    assign idx_last = (r_idx == LAST_IDX);

    // Scan step: skip taken IDs, tighten the bound, restart when a skipped ID reaches the bound
    assign cand_hit = ent_vld && (ent_id == r_cand);
    assign cand_inc = r_cand + ONE_ID;
    assign restart  = cand_hit && (cand_inc >= r_bound);

    always_comb begin
        n_cand  = r_cand;
        n_bound = r_bound;
        if (restart) begin
            n_cand  = (cand_inc >= LIMIT_ID) ? ONE_ID : cand_inc;
            n_bound = LIMIT_ID;
        end else if (cand_hit) begin
            n_cand = cand_inc;
        end else if (ent_vld && (ent_id > r_cand) && (r_bound > ent_id)) begin
            n_bound = ent_id;
        end
    end

    assign o_stat.scan_last = idx_last && !restart;

    // Next table index to visit
    assign n_idx = (i_cmd.load || (i_cmd.alloc_step && restart)) ? '0 : r_idx + 1'b1;

    // Release lookup
    assign rel_hit         = ent_vld && (ent_id == uida_pkg::ID_W'(r_rel));
    assign o_stat.rel_last = rel_hit || idx_last;

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = uida_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = uida_pkg::IDX_W'(i);
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_rel   <= i_release_id;
            r_full  <= o_stat.in_full;
            r_cand  <= start_cand;
            r_bound <= LIMIT_ID;
            r_idx   <= '0;
            r_hit   <= 1'b0;
        end else if (i_cmd.alloc_step) begin
            r_cand  <= n_cand;
            r_bound <= n_bound;
            r_idx   <= restart ? '0 : r_idx + 1'b1;
        end else if (i_cmd.rel_step) begin
            r_idx <= r_idx + 1'b1;
            if (rel_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
        end
    end

    // Fetch the table entry at the next index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.alloc_step || i_cmd.rel_step) begin
            r_ent <= r_table[n_idx];
        end
    end

    // Table contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && (r_op == uida_pkg::OP_ALLOC) && !r_full) begin
            r_table[free_idx] <= uida_pkg::PID_W'(r_cand);
        end
    end

    // Live state: valid bits, count, last given, safe bound
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_last  <= LIMIT_ID;
            r_safe  <= LIMIT_ID;
        end else begin
            if (i_cmd.alloc_step && o_stat.scan_last) begin
                r_safe <= n_bound;
            end
            if (i_cmd.finish) begin
                if (r_op == uida_pkg::OP_ALLOC) begin
                    if (!r_full) begin
                        r_valid[free_idx] <= 1'b1;
                        r_count           <= r_count + 1'b1;
                        r_last            <= r_cand;
                    end
                end else if (r_hit) begin
                    r_valid[r_hit_idx] <= 1'b0;
                    r_count            <= r_count - 1'b1;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_op == uida_pkg::OP_ALLOC) begin
                r_out_given  <= r_full ? '0 : uida_pkg::GIVEN_W'(r_cand);
                r_out_status <= r_full ? uida_pkg::ST_FULL : uida_pkg::ST_OK;
            end else begin
                r_out_given  <= '0;
                r_out_status <= r_hit ? uida_pkg::ST_OK : uida_pkg::ST_NOT_FOUND;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_given_id  = r_out_given;
    assign o_status    = r_out_status;

    // Count tracks the number of live slots
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("live count differs from valid bits");

    // Candidate stays a legal ID while scanning
    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_step |-> (r_cand >= ONE_ID) && (r_cand < LIMIT_ID))
        else $error("scan candidate out of range");

    // Never overwrite a result that has not been taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result register overrun");

endmodule

// ----- design/unique_id_allocator_core.sv -----
// Top level of the unique ID allocator: controller plus datapath.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------
//  i_in     | in  | valid / ready | opcode[0:0], release_id[5:0]
//  o_out    | out | valid / ready | given_id[5:0], status[1:0]
//
// One item at a time; ready is high only while the controller is idle.
// Allocate without a table scan, or on a full table: straight from idle to the finish state.
// Allocate with a scan: one pass over the table, one table entry per cycle; each restart
// when a skipped ID reaches the bound begins another pass from the first entry.
// Release: scans the table until the ID is found or the last entry is reached.
// Reset is synchronous: valid bits and count clear at once, no clearing pass.
// A result waiting in the output register stalls only the finish of the next item.
module unique_id_allocator_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    uida_in_if.sink          i_in,
    uida_out_if.source       o_out
);

    uida_pkg::t_cmd  cmd;
    uida_pkg::t_stat stat;
    logic            in_ready;

    assign i_in.ready = in_ready;

    // Sequence each item
    uida_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Table, scan and result storage
    uida_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_opcode     (i_in.opcode),
        .i_release_id (i_in.release_id),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_given_id   (o_out.given_id),
        .o_status     (o_out.status)
    );

endmodule

// ----- sim/unique_id_allocator_core_tb.sv -----
// Self-checking testbench of the unique ID allocator: random allocate/release traffic vs. a predictor.
module unique_id_allocator_core_tb;

    localparam int CLK_HALF   = 5;
    localparam int CYCLE_CAP  = 20_000_000;
    localparam int TAIL_WAIT  = 80;
    localparam int SHOW_LIMIT = 10;

    typedef struct {
        logic [uida_pkg::OPCODE_W-1:0] opcode;
        logic [uida_pkg::REL_W-1:0]    release_id;
    } t_request;

    typedef struct {
        logic [uida_pkg::GIVEN_W-1:0]  given_id;
        logic [uida_pkg::STATUS_W-1:0] status;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    uida_in_if  req_if ();
    uida_out_if res_if ();

    unique_id_allocator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Shadow state of the allocator
    logic [uida_pkg::PID_W-1:0] live_ids [uida_pkg::TABLE_DEPTH] = '{default: '0};
    bit                         slot_used [uida_pkg::TABLE_DEPTH] = '{default: 1'b0};
    int unsigned                n_live     = 0;
    int unsigned                prev_id    = uida_pkg::PID_LIMIT;
    int unsigned                window_top = uida_pkg::PID_LIMIT;

    t_request    pending_requests [$];
    t_outcome    pending_outcomes [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          err_count   = 0;
    int          cycle_count = 0;
    bit          req_taken;

    // Work out the result of one accepted request and advance the shadow state
    function automatic t_outcome compute_outcome(t_request r);
        t_outcome    res;
        int unsigned cand;
        int unsigned bound;
        int unsigned i;
        bit          do_scan;
        bit          placed;
        bit          found;
        res.given_id = '0;
        res.status   = uida_pkg::ST_OK;
        if (r.opcode == uida_pkg::OP_ALLOC) begin
            if (n_live >= uida_pkg::TABLE_DEPTH || n_live >= uida_pkg::PID_LIMIT - 1) begin
                res.status = uida_pkg::ST_FULL;
            end else begin
                cand    = prev_id + 1;
                do_scan = 1'b0;
                if (cand >= uida_pkg::PID_LIMIT) begin
                    cand    = 1;
                    do_scan = 1'b1;
                end else if (cand >= window_top) begin
                    do_scan = 1'b1;
                end
                // Skip taken IDs, tighten the bound, restart a pass on reaching it
                if (do_scan) begin
                    bound = uida_pkg::PID_LIMIT;
                    i     = 0;
                    while (i < uida_pkg::TABLE_DEPTH) begin
                        if (slot_used[i] && live_ids[i] == cand) begin
                            cand++;
                            if (cand >= bound) begin
                                if (cand >= uida_pkg::PID_LIMIT)
                                    cand = 1;
                                bound = uida_pkg::PID_LIMIT;
                                i     = 0;
                            end else begin
                                i++;
                            end
                        end else begin
                            if (slot_used[i] && live_ids[i] > cand && bound > live_ids[i])
                                bound = live_ids[i];
                            i++;
                        end
                    end
                    window_top = bound;
                end
                prev_id = cand;
                // Place the new ID in the lowest free slot
                placed = 1'b0;
                for (i = 0; i < uida_pkg::TABLE_DEPTH; i++) begin
                    if (!placed && !slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        live_ids[i]  = cand[uida_pkg::PID_W-1:0];
                        placed       = 1'b1;
                    end
                end
                n_live++;
                res.given_id = cand[uida_pkg::GIVEN_W-1:0];
            end
        end else begin
            res.status = uida_pkg::ST_NOT_FOUND;
            found      = 1'b0;
            for (i = 0; i < uida_pkg::TABLE_DEPTH; i++) begin
                if (!found && slot_used[i] && live_ids[i] == r.release_id) begin
                    slot_used[i] = 1'b0;
                    n_live--;
                    res.status = uida_pkg::ST_OK;
                    found      = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Queue one request for the driver
    function automatic void push_request(logic [uida_pkg::OPCODE_W-1:0] op, int unsigned id);
        t_request r;
        r.opcode     = op;
        r.release_id = id[uida_pkg::REL_W-1:0];
        pending_requests.push_back(r);
    endfunction

    // Queue random bursts: alloc-heavy ones fill the table, mixed ones churn it, release-heavy ones drain it
    function automatic void queue_random_requests(int n);
        int left;
        int len;
        int alloc_pct;
        int k;
        left = n;
        while (left > 0) begin
            len = $urandom_range(40, 6);
            case ($urandom_range(2, 0))
                0: begin
                    alloc_pct = 95;
                end
                1: begin
                    alloc_pct = 60;
                end
                default: begin
                    alloc_pct = 25;
                end
            endcase
            for (k = 0; k < len && left > 0; k++) begin
                if ($urandom_range(99, 0) < alloc_pct)
                    push_request(uida_pkg::OP_ALLOC, $urandom_range(63, 0));
                else
                    push_request(uida_pkg::OP_RELEASE, $urandom_range(63, 0));
                left--;
            end
        end
    endfunction

    // Hold the main sequence until every request is in and every result is back
    task automatic drain();
        while (pending_requests.size() != 0 || req_if.valid || pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Count cycles
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Drop the run on a hang
    initial begin
        wait (cycle_count >= CYCLE_CAP);
        $display("unique_id_allocator_core_tb: done, errors");
        $finish;
    end

    // Driver: present the next request at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid      <= 1'b0;
            req_if.opcode     <= uida_pkg::OP_ALLOC;
            req_if.release_id <= '0;
            res_if.ready      <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            if (!req_if.valid || req_taken) begin
                if (pending_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    req_if.valid      <= 1'b1;
                    req_if.opcode     <= pending_requests[0].opcode;
                    req_if.release_id <= pending_requests[0].release_id;
                    pending_requests.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results, then predict for accepted requests
    always @(posedge i_clk) begin
        t_request r;
        t_outcome want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (pending_outcomes.size() == 0) begin
                    err_count++;
                    if (err_count <= SHOW_LIMIT)
                        $display("unexpected result: expected none, got given_id=%0d status=%0d",
                                 res_if.given_id, res_if.status);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (res_if.given_id !== want.given_id) begin
                        err_count++;
                        if (err_count <= SHOW_LIMIT)
                            $display("given_id mismatch: expected %0d, got %0d",
                                     want.given_id, res_if.given_id);
                    end
                    if (res_if.status !== want.status) begin
                        err_count++;
                        if (err_count <= SHOW_LIMIT)
                            $display("status mismatch: expected %0d, got %0d",
                                     want.status, res_if.status);
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                r.opcode     = req_if.opcode;
                r.release_id = req_if.release_id;
                pending_outcomes.push_back(compute_outcome(r));
                req_taken <= 1'b1;
            end else begin
                req_taken <= 1'b0;
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 75;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first allocate wraps, misses on 0 and unused IDs, hit, double release
        push_request(uida_pkg::OP_ALLOC, 63);
        push_request(uida_pkg::OP_ALLOC, 0);
        push_request(uida_pkg::OP_ALLOC, 42);
        push_request(uida_pkg::OP_RELEASE, 0);
        push_request(uida_pkg::OP_RELEASE, 63);
        push_request(uida_pkg::OP_RELEASE, 2);
        push_request(uida_pkg::OP_RELEASE, 2);
        push_request(uida_pkg::OP_ALLOC, 21);
        push_request(uida_pkg::OP_RELEASE, 1);
        push_request(uida_pkg::OP_ALLOC, 0);
        push_request(uida_pkg::OP_RELEASE, 3);
        push_request(uida_pkg::OP_RELEASE, 4);
        push_request(uida_pkg::OP_RELEASE, 5);
        push_request(uida_pkg::OP_ALLOC, 63);
        push_request(uida_pkg::OP_RELEASE, 6);
        drain();

        // Fill past capacity so the table-full status shows up early
        for (int i = 0; i < uida_pkg::TABLE_DEPTH + 2; i++)
            push_request(uida_pkg::OP_ALLOC, $urandom_range(63, 0));
        queue_random_requests(400);
        drain();

        // Sender slow, receiver fast; pause midway for all results
        send_idle_pct = 75;
        recv_idle_pct = 18;
        queue_random_requests(215);
        drain();
        queue_random_requests(215);
        drain();

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_requests(430);
        drain();

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_count == 0 && pending_outcomes.size() == 0) begin
            $display("unique_id_allocator_core_tb: done, clean");
        end else begin
            $display("unique_id_allocator_core_tb: done, errors");
        end
        $finish;
    end

endmodule
